// ----- hw/rtl/fixed_point_arith_unit_defines.svh -----
// Assertion macros for the fixed-point arithmetic unit.
// Uses clk and rst_n of the including module; no other dependencies.
`ifndef FIXED_POINT_ARITH_UNIT_DEFINES_SVH
`define FIXED_POINT_ARITH_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define FPAU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FPAU_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FPAU_ASSERT(lbl, prop, msg)
`define FPAU_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- hw/rtl/fpau_pkg.sv -----
// Shared types, codes and helpers for the fixed-point arithmetic unit.
// No dependencies.
package fpau_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam logic [15:0] TOL_RST   = 16'd6;
    localparam logic [7:0]  STEPS_RST = 8'd64;

    // exact floor(x/3) for any 32-bit x: (x * RECIP3) >> 33
    localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

    localparam logic CFG_TOL   = 1'b0;
    localparam logic CFG_STEPS = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DIVZERO = 2'd1;
    localparam logic [1:0] ST_LIMIT   = 2'd2;

    typedef enum logic [2:0] {
        FN_MUL   = 3'd0,
        FN_DIV   = 3'd1,
        FN_FLOAT = 3'd2,
        FN_SQRT  = 3'd3,
        FN_CBRT  = 3'd4
    } func_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_MUL_FIN,
        S_FLOAT,
        S_DIV,
        S_DIV_WAIT,
        S_ROOT_DEN,
        S_ROOT_SQ,
        S_ROOT_DIV,
        S_ROOT_DWAIT,
        S_ROOT_DIFF,
        S_ROOT_THIRD,
        S_ROOT_UPD,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [15:0] tol;
        logic [7:0]  max_steps;
    } cfg_t;

    typedef struct packed {
        logic [31:0] result;
        logic [1:0]  status;
    } res_t;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? (32'd0 - v) : v;
    endfunction

endpackage

// ----- hw/rtl/fpau_mul.sv -----
// Shared 32x32 unsigned multiplier with registered product.
// Depends on nothing.
module fpau_mul (
    input  logic        clk,
    input  logic        start,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= 64'(op_a) * 64'(op_b);
        end
    end

    assign prod = prod_reg;

endmodule

// ----- hw/rtl/fpau_div.sv -----
// Bit-serial restoring divider: (c << FRAC_BITS) / d, one quotient bit per cycle.
// Depends on nothing; d must be nonzero.
module fpau_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] c,
    input  logic [31:0] d,
    output logic        done,
    output logic [31:0] quo
);

    localparam int W  = 32 + FRAC_BITS;
    localparam int CW = $clog2(W + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [31:0]   rem_reg, rem_next;
    logic [W-1:0]  sh_reg, sh_next;
    logic [31:0]   d_reg;
    logic [32:0]   rem_sh;
    logic          ge;

    assign rem_sh = {rem_reg, sh_reg[W-1]};
    assign ge     = rem_sh >= {1'b0, d_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        if (start)
        begin
            cnt_next = CW'(W);
            rem_next = 32'd0;
            sh_next  = {c, {FRAC_BITS{1'b0}}};
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
            rem_next  = ge ? 32'(rem_sh - {1'b0, d_reg}) : rem_sh[31:0];
            sh_next   = {sh_reg[W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        if (start)
        begin
            d_reg <= d;
        end
    end

    assign done = done_reg;
    assign quo  = sh_reg[31:0];

endmodule

// ----- hw/rtl/fpau_ctrl.sv -----
// Sequencer and datapath registers; drives the shared multiplier and divider.
// Depends on fpau_pkg, fpau_mul, fpau_div.
module fpau_ctrl #(
    parameter int FRAC_BITS = fpau_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [2:0]      in_func,
    input  logic [31:0]     in_a,
    input  logic [31:0]     in_b,
    input  fpau_pkg::cfg_t  cfg,
    input  logic            out_take,
    output logic            out_valid,
    output fpau_pkg::res_t  out_res
);

    localparam int SH_BIAS = 150 - FRAC_BITS;
    localparam logic [31:0] T_INIT = 32'(2) << FRAC_BITS;

    fpau_pkg::state_t state_reg, state_next;
    fpau_pkg::func_t  func_reg, func_next;

    logic [31:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [31:0] t_reg, t_next;
    logic [31:0] den_reg, den_next;
    logic [31:0] diff_reg, diff_next;
    logic [31:0] smag_reg, smag_next;
    logic [7:0]  n_reg, n_next;
    logic [31:0] res_reg, res_next;
    logic [1:0]  st_reg, st_next;
    logic        sign_reg, sign_next;

    logic        mul_start, div_start, div_done;
    logic [31:0] mul_a, mul_b, div_c, div_d, div_quo;
    logic [63:0] prod;

    logic [31:0] prod_fx, quo_s, dt, t_upd, float_val;
    logic        is_cube, stop_tol, stop_lim;
    logic [8:0]  limit;
    logic [9:0]  fsh, fnsh;
    logic [31:0] man;

    fpau_mul u_mul (
        .clk   (clk),
        .start (mul_start),
        .op_a  (mul_a),
        .op_b  (mul_b),
        .prod  (prod)
    );

    fpau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .c     (div_c),
        .d     (div_d),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign prod_fx  = prod[FRAC_BITS+31:FRAC_BITS];
    assign quo_s    = sign_reg ? (32'd0 - div_quo) : div_quo;
    assign is_cube  = (func_reg == fpau_pkg::FN_CBRT);
    assign dt       = diff_reg[31] ? (32'd0 - smag_reg) : smag_reg;
    assign t_upd    = t_reg + dt;
    assign limit    = (cfg.max_steps == 8'd0) ? 9'd1 : {1'b0, cfg.max_steps};
    assign stop_tol = smag_reg <= {16'd0, cfg.tol};
    assign stop_lim = ({1'b0, n_reg} + 9'd1) >= limit;

    // float: shift = exponent - 127 + FRAC_BITS - 23
    assign fsh  = {2'b00, a_reg[30:23]} - 10'(SH_BIAS);
    assign fnsh = 10'd0 - fsh;
    assign man  = {8'd0, 1'b1, a_reg[22:0]};

    always_comb
    begin
        logic [31:0] mag;
        mag = 32'd0;
        if (a_reg[30:0] != 31'd0)
        begin
            if (!fsh[9])
            begin
                mag = (fsh < 10'd32) ? (man << fsh[4:0]) : 32'd0;
            end
            else
            begin
                mag = (fnsh < 10'd32) ? (man >> fnsh[4:0]) : 32'd0;
            end
        end
        float_val = a_reg[31] ? (32'd0 - mag) : mag;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fpau_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    case (fpau_pkg::func_t'(in_func))
                        fpau_pkg::FN_MUL:   state_next = fpau_pkg::S_MUL;
                        fpau_pkg::FN_DIV:   state_next = fpau_pkg::S_DIV;
                        fpau_pkg::FN_FLOAT: state_next = fpau_pkg::S_FLOAT;
                        fpau_pkg::FN_SQRT:  state_next = fpau_pkg::S_ROOT_DEN;
                        fpau_pkg::FN_CBRT:  state_next = fpau_pkg::S_ROOT_DEN;
                        default:            state_next = fpau_pkg::S_DONE;
                    endcase
                end
            end
            fpau_pkg::S_MUL:     state_next = fpau_pkg::S_MUL_FIN;
            fpau_pkg::S_MUL_FIN: state_next = fpau_pkg::S_DONE;
            fpau_pkg::S_FLOAT:   state_next = fpau_pkg::S_DONE;
            fpau_pkg::S_DIV:
            begin
                state_next = (b_reg == 32'd0) ? fpau_pkg::S_DONE : fpau_pkg::S_DIV_WAIT;
            end
            fpau_pkg::S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = fpau_pkg::S_DONE;
                end
            end
            fpau_pkg::S_ROOT_DEN:
            begin
                state_next = is_cube ? fpau_pkg::S_ROOT_SQ : fpau_pkg::S_ROOT_DIV;
            end
            fpau_pkg::S_ROOT_SQ: state_next = fpau_pkg::S_ROOT_DIV;
            fpau_pkg::S_ROOT_DIV:
            begin
                state_next = (den_reg == 32'd0) ? fpau_pkg::S_DONE
                                                : fpau_pkg::S_ROOT_DWAIT;
            end
            fpau_pkg::S_ROOT_DWAIT:
            begin
                if (div_done)
                begin
                    state_next = fpau_pkg::S_ROOT_DIFF;
                end
            end
            fpau_pkg::S_ROOT_DIFF:
            begin
                state_next = is_cube ? fpau_pkg::S_ROOT_THIRD : fpau_pkg::S_ROOT_UPD;
            end
            fpau_pkg::S_ROOT_THIRD: state_next = fpau_pkg::S_ROOT_UPD;
            fpau_pkg::S_ROOT_UPD:
            begin
                state_next = (stop_tol || stop_lim) ? fpau_pkg::S_DONE
                                                    : fpau_pkg::S_ROOT_DEN;
            end
            fpau_pkg::S_DONE:
            begin
                if (out_take)
                begin
                    state_next = fpau_pkg::S_IDLE;
                end
            end
            default: state_next = fpau_pkg::S_IDLE;
        endcase
    end

    // unit controls
    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = fpau_pkg::mag32(a_reg);
        mul_b     = fpau_pkg::mag32(b_reg);
        div_start = 1'b0;
        div_c     = fpau_pkg::mag32(a_reg);
        div_d     = fpau_pkg::mag32(b_reg);
        case (state_reg)
            fpau_pkg::S_MUL:
            begin
                mul_start = 1'b1;
            end
            fpau_pkg::S_DIV:
            begin
                div_start = (b_reg != 32'd0);
            end
            fpau_pkg::S_ROOT_DEN:
            begin
                mul_start = is_cube;
                mul_a     = fpau_pkg::mag32(t_reg);
                mul_b     = fpau_pkg::mag32(t_reg);
            end
            fpau_pkg::S_ROOT_DIV:
            begin
                div_start = (den_reg != 32'd0);
                div_d     = fpau_pkg::mag32(den_reg);
            end
            fpau_pkg::S_ROOT_DIFF:
            begin
                mul_start = is_cube;
                mul_a     = fpau_pkg::mag32(diff_reg);
                mul_b     = fpau_pkg::RECIP3;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        func_next = func_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        t_next    = t_reg;
        den_next  = den_reg;
        diff_next = diff_reg;
        smag_next = smag_reg;
        n_next    = n_reg;
        res_next  = res_reg;
        st_next   = st_reg;
        sign_next = sign_reg;
        case (state_reg)
            fpau_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next = fpau_pkg::func_t'(in_func);
                    a_next    = in_a;
                    b_next    = in_b;
                    t_next    = T_INIT;
                    n_next    = 8'd0;
                    res_next  = 32'd0;
                    st_next   = fpau_pkg::ST_OK;
                    sign_next = in_a[31] ^ in_b[31];
                end
            end
            fpau_pkg::S_MUL_FIN:
            begin
                res_next = sign_reg ? (32'd0 - prod_fx) : prod_fx;
            end
            fpau_pkg::S_FLOAT:
            begin
                res_next = float_val;
            end
            fpau_pkg::S_DIV:
            begin
                if (b_reg == 32'd0)
                begin
                    st_next = fpau_pkg::ST_DIVZERO;
                end
            end
            fpau_pkg::S_DIV_WAIT:
            begin
                res_next = quo_s;
            end
            fpau_pkg::S_ROOT_DEN:
            begin
                den_next = t_reg;
            end
            fpau_pkg::S_ROOT_SQ:
            begin
                den_next = prod_fx;
            end
            fpau_pkg::S_ROOT_DIV:
            begin
                sign_next = a_reg[31] ^ den_reg[31];
                if (den_reg == 32'd0)
                begin
                    res_next = 32'd0;
                    st_next  = fpau_pkg::ST_DIVZERO;
                end
            end
            fpau_pkg::S_ROOT_DWAIT:
            begin
                diff_next = quo_s - t_reg;
            end
            fpau_pkg::S_ROOT_DIFF:
            begin
                smag_next = fpau_pkg::mag32(diff_reg) >> 1;
            end
            fpau_pkg::S_ROOT_THIRD:
            begin
                smag_next = {1'b0, prod[63:33]};
            end
            fpau_pkg::S_ROOT_UPD:
            begin
                t_next   = t_upd;
                n_next   = n_reg + 8'd1;
                res_next = t_upd;
                if (!stop_tol && stop_lim)
                begin
                    st_next = fpau_pkg::ST_LIMIT;
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fpau_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        t_reg    <= t_next;
        den_reg  <= den_next;
        diff_reg <= diff_next;
        smag_reg <= smag_next;
        n_reg    <= n_next;
        res_reg  <= res_next;
        st_reg   <= st_next;
        sign_reg <= sign_next;
    end

    assign in_ready       = (state_reg == fpau_pkg::S_IDLE);
    assign out_valid      = (state_reg == fpau_pkg::S_DONE);
    assign out_res.result = res_reg;
    assign out_res.status = st_reg;

endmodule

// ----- hw/rtl/fixed_point_arith_unit.sv -----
// Signed fixed-point arithmetic unit: multiply, divide, float conversion, roots.
// Top level; depends on fpau_pkg, fpau_ctrl and fixed_point_arith_unit_defines.svh.
//
// Usage:
//  - Slave stream (s_*) takes one operation per transfer; master stream (m_*)
//    returns exactly one result per operation, in order.
//  - Config channel (cfg_*) writes newton_tolerance (index 0) and
//    newton_max_steps (index 1); always ready, write only while idle.
//  - One operation at a time: s_tready is low from acceptance until the
//    result moves into the output register.
//  - Sequencing: multiply runs S_MUL then S_MUL_FIN, float runs S_FLOAT,
//    other codes go straight to S_DONE, divide waits on the serial divider,
//    and each Newton step runs one division, plus a squaring and a divide
//    by three for cube root; the 32+FRAC_BITS step divider sets step cost.
//  - Output register: a finished result waits in m_* while the next operation
//    is accepted and computed; a stalled receiver only holds up the sequencer
//    once it has the following result ready.
//  - Reset clears the sequencer, output valid and loads config defaults
//    (tolerance 6, max steps 64).
`include "fixed_point_arith_unit_defines.svh"
module fixed_point_arith_unit #(
    parameter int FRAC_BITS = fpau_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [2:0] func, [34:3] operand_a, [66:35] operand_b, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] result, [33:32] status, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    fpau_pkg::cfg_t cfg_reg, cfg_next;
    fpau_pkg::res_t res_c;
    fpau_pkg::res_t m_res_reg;
    logic           m_valid_reg, m_valid_next;
    logic           c_ready, c_valid, take;

    // config registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                fpau_pkg::CFG_TOL:   cfg_next.tol       = cfg_data;
                fpau_pkg::CFG_STEPS: cfg_next.max_steps = cfg_data[7:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    fpau_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (c_ready),
        .in_func   (s_tdata[2:0]),
        .in_a      (s_tdata[34:3]),
        .in_b      (s_tdata[66:35]),
        .cfg       (cfg_reg),
        .out_take  (take),
        .out_valid (c_valid),
        .out_res   (res_c)
    );

    // result moves to the output register when it is empty or being drained
    assign take         = c_valid && (!m_valid_reg || m_tready);
    assign m_valid_next = take || (m_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tol       <= fpau_pkg::TOL_RST;
            cfg_reg.max_steps <= fpau_pkg::STEPS_RST;
            m_valid_reg       <= 1'b0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            m_res_reg <= res_c;
        end
    end

    assign s_tready  = c_ready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {6'd0, m_res_reg.status, m_res_reg.result};

    `FPAU_ASSERT(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready, "accepted while busy")
    `FPAU_ASSERT(a_dz_zero, m_tvalid && m_tdata[33:32] == fpau_pkg::ST_DIVZERO |-> m_tdata[31:0] == 32'd0, "div-by-zero result not zero")
    `FPAU_ASSERT(a_status_code, m_tvalid |-> m_tdata[33:32] != 2'd3, "bad status code")
    `FPAU_ASSERT_RST(a_rst_idle, !rst_n |=> !m_tvalid, "output valid after reset")

endmodule
